// ===== hdl/stax_pkg.sv =====
// Shared types, constants and tables of the spherical texel address core.
// No dependencies; stax_isqrt, stax_cordic and spherical_texel_address_core import it.
package stax_pkg;

  localparam int CordicW = 36;  // covers a 2^32.5 vector grown by the CORDIC gain
  localparam int TableLen = 24;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] ThreeQuarter = 32'hC000_0000;
  // ceil(2^52 / 360): degree to 2^-32 turn, exact after the >> 20
  localparam logic [43:0] RotRecip = 44'd12509998964919;
  localparam logic [8:0] MaxDegrees = 9'd360;

  typedef enum logic [1:0] {
    REG_ROTATION = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_NONE     = 2'd3
  } reg_index_t;

  typedef logic signed [CordicW-1:0] cvec_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/stax_delay.sv =====
// Fixed-length shift register that keeps side data aligned with the datapath.
// Depends on nothing.
module stax_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) taps[k] <= '0;
    end else begin
      taps[0] <= d;
      for (int k = 1; k < DEPTH; k++) taps[k] <= taps[k-1];
    end
  end

  assign q = taps[DEPTH-1];
endmodule

// ===== hdl/stax_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, 32 stages.
// Depends on stax_pkg only through the import convention.
module stax_isqrt
  import stax_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] sum_in,
  output logic [31:0] root
);
  logic [63:0] rem [33];
  logic [63:0] res [33];

  assign rem[0] = sum_in;
  assign res[0] = '0;

  for (genvar k = 0; k < 32; k++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res[k] + Bit;
    always_ff @(posedge clk) begin
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + Bit;
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign root = res[32][31:0];
endmodule

// ===== hdl/stax_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (re, im) in 2^-32 turn, one step per stage.
// Depends on stax_pkg for the datapath width and the arctangent table.
module stax_cordic
  import stax_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  cvec_t       re_in,
  input  cvec_t       im_in,
  output logic [31:0] ang_out
);
  cvec_t       re  [STEPS+1];
  cvec_t       im  [STEPS+1];
  logic [31:0] ang [STEPS+1];

  // left half plane: turn by half a turn first
  always_comb begin
    if (re_in < 0) begin
      re[0]  = -re_in;
      im[0]  = -im_in;
      ang[0] = HalfTurn;
    end else begin
      re[0]  = re_in;
      im[0]  = im_in;
      ang[0] = '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (im[i] > 0) begin
        re[i+1]  <= re[i] + (im[i] >>> i);
        im[i+1]  <= im[i] - (re[i] >>> i);
        ang[i+1] <= ang[i] + atan_turn(5'(i));
      end else begin
        re[i+1]  <= re[i] - (im[i] >>> i);
        im[i+1]  <= im[i] + (re[i] >>> i);
        ang[i+1] <= ang[i] - atan_turn(5'(i));
      end
    end
  end

  assign ang_out = ang[STEPS];
endmodule

// ===== hdl/spherical_texel_address_core.sv =====
// Equirectangular texel address from a local hit point.
// The 32-stage square root and the polar CORDIC run in series and set the
// latency from start to done.
// Throughput one point per clock; busy stays low and results cannot be held.
// Synchronous active-high reset restores the register defaults and empties the pipe.
// Depends on stax_pkg, stax_delay, stax_isqrt and stax_cordic.
module spherical_texel_address_core
  import stax_pkg::*;
#(
  parameter int COORD_BITS   = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16,
  parameter int DIM_BITS     = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [12:0]                  wr_data,
  output logic                         done,
  output logic [DIM_BITS-1:0]          texel_col,
  output logic [DIM_BITS-1:0]          texel_row,
  output logic                         degenerate
);
  localparam int Guard = 32 - COORD_BITS;
  localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int RootLat = 33;  // square stage plus square root
  localparam logic [16:0] DimLim = 17'd1 << DIM_BITS;

  // configuration
  logic [8:0]  rotation_degrees;
  logic [12:0] texture_width;
  logic [12:0] texture_height;
  logic [31:0] rot;
  logic [DIM_BITS-1:0] wm1;
  logic [DIM_BITS-1:0] hm1;

  function automatic logic [DIM_BITS-1:0] dim_m1(input logic [12:0] d);
    logic [16:0] v;
    v = (d == '0) ? 17'd1 : 17'(d);
    if (v > DimLim) v = DimLim;
    return DIM_BITS'(v - 17'd1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_degrees <= '0;
      texture_width    <= 13'd1024;
      texture_height   <= 13'd512;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_ROTATION: rotation_degrees <= wr_data[8:0];
        REG_WIDTH:    texture_width    <= wr_data;
        REG_HEIGHT:   texture_height   <= wr_data;
        default: ;
      endcase
    end
  end

  logic [8:0]  rot_sat;
  logic [52:0] rot_prod;
  assign rot_sat  = (rotation_degrees > MaxDegrees) ? MaxDegrees : rotation_degrees;
  assign rot_prod = 53'(rot_sat) * 53'(RotRecip);

  // derived settings are registered and follow the registers in the next cycle
  always_ff @(posedge clk) begin
    rot <= rot_prod[51:20];
    wm1 <= dim_m1(texture_width);
    hm1 <= dim_m1(texture_height);
  end

  assign busy = 1'b0;

  // input stage
  logic signed [31:0] xs, ys, zs;
  logic               v0, deg0, xz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    xs   <= 32'(point_x) <<< Guard;
    ys   <= 32'(point_y) <<< Guard;
    zs   <= 32'(point_z) <<< Guard;
    deg0 <= (point_x == '0) && (point_y == '0) && (point_z == '0);
    xz0  <= (point_x == '0) && (point_z == '0);
  end

  // squares of the horizontal components
  logic [31:0] ax, azm;
  logic [63:0] sum_sq;
  assign ax  = xs[31] ? 32'(-xs) : 32'(xs);
  assign azm = zs[31] ? 32'(-zs) : 32'(zs);

  always_ff @(posedge clk) begin
    sum_sq <= 64'(ax) * 64'(ax) + 64'(azm) * 64'(azm);
  end

  logic [31:0] rho;
  stax_isqrt u_isqrt (
    .clk    (clk),
    .sum_in (sum_sq),
    .root   (rho)
  );

  logic [31:0] y_al;
  stax_delay #(.WIDTH(32), .DEPTH(RootLat)) u_ydly (
    .clk (clk),
    .rst (rst),
    .d   (ys),
    .q   (y_al)
  );

  logic [31:0] polar_raw;
  stax_cordic #(.STEPS(Steps)) u_polar (
    .clk     (clk),
    .re_in   (CordicW'($signed(y_al))),
    .im_in   (CordicW'({1'b0, rho})),
    .ang_out (polar_raw)
  );

  logic [31:0] az_raw, az_al;
  stax_cordic #(.STEPS(Steps)) u_azim (
    .clk     (clk),
    .re_in   (CordicW'(zs)),
    .im_in   (CordicW'(xs)),
    .ang_out (az_raw)
  );

  stax_delay #(.WIDTH(32), .DEPTH(RootLat)) u_azdly (
    .clk (clk),
    .rst (rst),
    .d   (az_raw),
    .q   (az_al)
  );

  // valid, origin, vertical axis, y above the horizontal plane
  logic [3:0] side_al;
  stax_delay #(.WIDTH(4), .DEPTH(RootLat + Steps)) u_sdly (
    .clk (clk),
    .rst (rst),
    .d   ({v0, deg0, xz0, ~ys[31] && (ys != '0)}),
    .q   (side_al)
  );

  // angle fix-up and rotation
  logic [31:0] polar_fix, az_rot;
  always_comb begin
    if (side_al[1]) begin
      polar_fix = side_al[0] ? '0 : HalfTurn;
    end else if (polar_raw > ThreeQuarter) begin
      polar_fix = '0;
    end else if (polar_raw > HalfTurn) begin
      polar_fix = HalfTurn;
    end else begin
      polar_fix = polar_raw;
    end
    az_rot = (side_al[1] ? 32'd0 : az_al) + rot;
  end

  logic [ANGLE_BITS-1:0] u_q, p_q;
  logic                  v1, deg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= side_al[3];
    end
    deg1 <= side_al[2];
    u_q  <= az_rot[31 -: ANGLE_BITS];
    p_q  <= polar_fix[31 -: ANGLE_BITS];
  end

  // scale to texels and register the result
  logic [DIM_BITS+ANGLE_BITS-1:0] col_prod, row_prod;
  assign col_prod = (DIM_BITS+ANGLE_BITS)'(wm1) * (DIM_BITS+ANGLE_BITS)'(u_q);
  assign row_prod = (DIM_BITS+ANGLE_BITS)'(hm1) * (DIM_BITS+ANGLE_BITS)'(p_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    degenerate <= deg1;
    texel_col  <= deg1 ? '0 : col_prod[ANGLE_BITS +: DIM_BITS];
    texel_row  <= deg1 ? '0 : row_prod[ANGLE_BITS-1 +: DIM_BITS];
  end

endmodule
